/* rtl/kcc_pkg.sv */
package kcc_pkg;

   // Number of key lanes built by default
   localparam int KEYS_DEF = 3;

   // Fixed widths of the scan input and of each event vector
   localparam int LEVEL_W = 3;
   localparam int EVENT_W = 3;

   // Counter and register widths
   localparam int TICK_W = 8;
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Register file
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_WINDOW = 8'd1;
   localparam logic [TICK_W-1:0] LONG_PRESS_RST = 8'd70;
   localparam logic [TICK_W-1:0] DOUBLE_WINDOW_RST = 8'd35;

   // Events found by one lane in one tick
   typedef struct packed {
      logic short_hit;
      logic double_hit;
      logic long_hit;
   } kcc_evt_type;

endpackage

/* rtl/key_click_classifier.sv */
// Key click classifier: each accepted transaction is one scan tick of active-low
// key levels; every key runs its own debounce lane (idle, confirm, held) with a
// saturating held counter and a double-click window, and the lanes' findings are
// merged into one result of short, double and long press pulses per tick. A
// tick is accepted each cycle the single output register is free or draining; its
// result appears there in the cycle after acceptance, and a new tick is taken in
// the same cycle that the previous result is taken. Keys beyond the three input
// bits read as released and never report. The user must write the two thresholds
// through the csr_ port with no tick in flight; the block does not enforce it.
module key_click_classifier #(
   parameter int KEYS = kcc_pkg::KEYS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kcc_pkg::LEVEL_W-1:0]      req_key_levels,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [kcc_pkg::EVENT_W-1:0]      rsp_short_events,
   output logic [kcc_pkg::EVENT_W-1:0]      rsp_double_events,
   output logic [kcc_pkg::EVENT_W-1:0]      rsp_long_events,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kcc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import kcc_pkg::*;

   logic [TICK_W-1:0]          long_press_ff;
   logic [TICK_W-1:0]          double_window_ff;
   logic                       advance;
   kcc_evt_type [KEYS-1:0]     lane_evt;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff    <= LONG_PRESS_RST;
         double_window_ff <= DOUBLE_WINDOW_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_LONG_PRESS) begin
            long_press_ff <= csr_data[TICK_W-1:0];
         end
         if (csr_index == CSR_DOUBLE_WINDOW) begin
            double_window_ff <= csr_data[TICK_W-1:0];
         end
      end
   end

   assign advance = req_valid && req_ready;

   // One debounce lane per key
   for (genvar k = 0; k < KEYS; k++) begin : g_key
      logic released;
      if (k < LEVEL_W) begin : g_pin
         assign released = req_key_levels[k];
      end else begin : g_open
         assign released = 1'b1;
      end
      kcc_lane u_lane (
         .clock               (clock),
         .reset               (reset),
         .advance             (advance),
         .released            (released),
         .long_press_ticks    (long_press_ff),
         .double_window_ticks (double_window_ff),
         .evt                 (lane_evt[k])
      );
   end

   // Merge lane events into the result register
   kcc_merge #(
      .KEYS (KEYS)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_valid),
      .in_ready          (req_ready),
      .lane_evt          (lane_evt),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_short_events  (rsp_short_events),
      .rsp_double_events (rsp_double_events),
      .rsp_long_events   (rsp_long_events)
   );

endmodule

/* rtl/kcc_lane.sv */
module kcc_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        released,
   input  logic [kcc_pkg::TICK_W-1:0]  long_press_ticks,
   input  logic [kcc_pkg::TICK_W-1:0]  double_window_ticks,
   output kcc_pkg::kcc_evt_type        evt
);
   import kcc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_CONFIRM = 2'd1,
      PH_HELD    = 2'd2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] held_ff, held_in;
   logic              wopen_ff, wopen_in;
   logic [TICK_W-1:0] wticks_ff, wticks_in;
   logic              double_hit, long_hit, short_hit;

   // Debounce phase step, then the click window count
   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      wopen_in   = wopen_ff;
      wticks_in  = wticks_ff;
      double_hit = 1'b0;
      long_hit   = 1'b0;
      short_hit  = 1'b0;
      case (phase_ff)
         PH_CONFIRM: begin
            phase_in = released ? PH_IDLE : PH_HELD;
         end
         PH_HELD: begin
            if (released) begin
               if (held_ff <= long_press_ticks) begin
                  if (!wopen_ff) begin
                     wopen_in  = 1'b1;
                     wticks_in = '0;
                  end else begin
                     double_hit = 1'b1;
                     wopen_in   = 1'b0;
                  end
               end else begin
                  long_hit = 1'b1;
               end
               phase_in = PH_IDLE;
            end else if (held_ff != TICK_MAX) begin
               held_in = held_ff + TICK_W'(1);
            end
         end
         default: begin
            // idle, and the unused code that behaves as idle
            if (!released) begin
               phase_in = PH_CONFIRM;
               held_in  = '0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
      // count the window also in the tick that opens it
      if (wopen_in) begin
         if (wticks_in != TICK_MAX) begin
            wticks_in = wticks_in + TICK_W'(1);
         end
         if (wticks_in >= double_window_ticks) begin
            short_hit = 1'b1;
            wopen_in  = 1'b0;
         end
      end
   end

   assign evt.short_hit  = short_hit;
   assign evt.double_hit = double_hit;
   assign evt.long_hit   = long_hit;

   // Advance lane state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         held_ff   <= '0;
         wopen_ff  <= 1'b0;
         wticks_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         wopen_ff  <= wopen_in;
         wticks_ff <= wticks_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_double_needs_window: assert property (@(posedge clock) disable iff (reset)
      double_hit |-> wopen_ff)
      else $error("double click without an open window");
   a_short_double_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({short_hit, double_hit}))
      else $error("short and double press in the same tick");
   a_confirm_leaves: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_CONFIRM) |=> (phase_ff != PH_CONFIRM))
      else $error("confirm phase held over a tick");
`endif

endmodule

/* rtl/kcc_merge.sv */
module kcc_merge #(
   parameter int KEYS = kcc_pkg::KEYS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  kcc_pkg::kcc_evt_type [KEYS-1:0]       lane_evt,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [kcc_pkg::EVENT_W-1:0]           rsp_short_events,
   output logic [kcc_pkg::EVENT_W-1:0]           rsp_double_events,
   output logic [kcc_pkg::EVENT_W-1:0]           rsp_long_events
);
   import kcc_pkg::*;

   logic [EVENT_W-1:0] short_in, double_in, long_in;
   logic [EVENT_W-1:0] short_ff, double_ff, long_ff;
   logic               valid_ff;
   logic               take;

   // Gather lane events; keys beyond the output width are dropped
   for (genvar i = 0; i < EVENT_W; i++) begin : g_bit
      if (i < KEYS) begin : g_lane
         assign short_in[i]  = lane_evt[i].short_hit;
         assign double_in[i] = lane_evt[i].double_hit;
         assign long_in[i]   = lane_evt[i].long_hit;
      end else begin : g_none
         assign short_in[i]  = 1'b0;
         assign double_in[i] = 1'b0;
         assign long_in[i]   = 1'b0;
      end
   end

   // Take a new transaction whenever the output register is free or draining
   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Hold the result payload until it is taken
   always_ff @(posedge clock) begin
      if (take) begin
         short_ff  <= short_in;
         double_ff <= double_in;
         long_ff   <= long_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_short_events  = short_ff;
   assign rsp_double_events = double_ff;
   assign rsp_long_events   = long_ff;

endmodule
